>>> hw/rtl/imma_pkg.sv
// Shared types, codes and default sizes for the integer matrix multiply-accumulate core.
`default_nettype none

package imma_pkg;

    localparam int DEF_MAX_DIM    = 64;
    localparam int DEF_ELEM_WIDTH = 32;

    // command codes
    localparam logic [2:0] CMD_WR_A = 3'd0;
    localparam logic [2:0] CMD_WR_B = 3'd1;
    localparam logic [2:0] CMD_WR_C = 3'd2;
    localparam logic [2:0] CMD_RUN  = 3'd3;
    localparam logic [2:0] CMD_RD_C = 3'd4;

    // result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    // register indexes (paddr bit 2)
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_SIZE = 1'b1;

    localparam logic [6:0] DIM_RESET = 7'd64;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
    } s_payload_t;

    typedef struct packed {
        logic               kind;
        logic [5:0]         out_row;
        logic [5:0]         out_col;
        logic signed [31:0] out_value;
    } m_payload_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/integer_matrix_multiply_accumulate_core.sv
// Top level of the integer matrix multiply-accumulate core: command sequencer and shared MAC.
`default_nettype none

// Channel   Dir  Handshake                    Word
// s_        in   s_valid / s_ready            s_payload_t: cmd, row, col, value
// m_        out  m_valid / m_ready            m_payload_t: kind, out_row, out_col, out_value
// apb       in   psel, penable, pwrite; pready out  rows_in_use @0x0, size_in_use @0x4
//
// Timing: a write of A, B or C is taken in the idle state. A read of C passes
// through the registered RAM read and then waits for the output register. A run
// issues rows*size*size products through the one shared multiplier and adder
// (one product per cycle), then drains the MAC pipeline and reports.
// Reset: after aresetn all 2^(2*ceil(log2 MAX_DIM)) entries of the C store (4096
// at the default) are swept to zero, one entry a cycle; no word is taken then.
// Stalls: m_ready low holds the result in the output register; the sequencer
// waits with it and takes writes only from the idle state.

module integer_matrix_multiply_accumulate_core
    import imma_pkg::*;
#(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire s_payload_t  s_data,

    output logic             m_valid,
    input  wire logic        m_ready,
    output m_payload_t       m_data,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int LIM_W  = ($clog2(MAX_DIM + 1) > 7) ? $clog2(MAX_DIM + 1) : 7;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [6:0] rows_reg;
    logic [6:0] size_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_SIZE) ? 32'(size_reg) : 32'(rows_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= DIM_RESET;
            size_reg <= DIM_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_SIZE) begin
                size_reg <= pwdata[6:0];
            end else begin
                rows_reg <= pwdata[6:0];
            end
        end
    end

    // limits clamped to the store size
    logic [LIM_W-1:0] nr_lim;
    logic [LIM_W-1:0] ns_lim;

    always_comb begin
        nr_lim = (LIM_W'(rows_reg) > LIM_W'(MAX_DIM)) ? LIM_W'(MAX_DIM) : LIM_W'(rows_reg);
        ns_lim = (LIM_W'(size_reg) > LIM_W'(MAX_DIM)) ? LIM_W'(MAX_DIM) : LIM_W'(size_reg);
    end

    // ------------------------------------------------------------------
    // stores
    // ------------------------------------------------------------------
    logic                  a_we, b_we, c_we;
    logic [ADDR_W-1:0]     ab_waddr;
    logic [ELEM_WIDTH-1:0] ab_wdata;
    logic [ADDR_W-1:0]     c_waddr;
    logic [ELEM_WIDTH-1:0] c_wdata;
    logic                  ab_re, c_re;
    logic [ADDR_W-1:0]     a_raddr, b_raddr, c_raddr;
    logic [ELEM_WIDTH-1:0] a_rdata, b_rdata, c_rdata;

    imma_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_a_ram (
        .aclk (aclk), .we (a_we), .waddr (ab_waddr), .wdata (ab_wdata),
        .re (ab_re), .raddr (a_raddr), .rdata (a_rdata)
    );

    imma_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_b_ram (
        .aclk (aclk), .we (b_we), .waddr (ab_waddr), .wdata (ab_wdata),
        .re (ab_re), .raddr (b_raddr), .rdata (b_rdata)
    );

    imma_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_c_ram (
        .aclk (aclk), .we (c_we), .waddr (c_waddr), .wdata (c_wdata),
        .re (c_re), .raddr (c_raddr), .rdata (c_rdata)
    );

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  k_reg, k_next;

    // captured read command
    logic [5:0]        rd_row_reg, rd_col_reg;
    logic              rd_in_reg;

    // MAC pipeline: stage 1 = RAM data, stage 2 = product
    logic              p1_vld_reg, p1_first_reg, p1_last_reg;
    logic [IDX_W-1:0]  p1_i_reg, p1_j_reg;
    logic              p2_vld_reg, p2_first_reg, p2_last_reg;
    logic [IDX_W-1:0]  p2_i_reg, p2_j_reg;
    logic [ELEM_WIDTH-1:0] prod_reg, cbase_reg, acc_reg;
    logic [ELEM_WIDTH-1:0] acc_sum;

    // output register
    logic              m_valid_reg;
    m_payload_t        m_data_reg;
    logic              out_load;
    m_payload_t        out_next;

    logic              s_acc;
    logic              in_range;
    logic [IDX_W-1:0]  row_i, col_i;
    logic              issue;
    logic              last_k, last_j, last_i;
    logic              out_free;

    assign s_acc    = s_valid & s_ready;
    assign in_range = (int'(s_data.row) < MAX_DIM) && (int'(s_data.col) < MAX_DIM);
    assign row_i    = IDX_W'(s_data.row);
    assign col_i    = IDX_W'(s_data.col);
    assign last_k   = (LIM_W'(k_reg) == ns_lim - LIM_W'(1));
    assign last_j   = (LIM_W'(j_reg) == ns_lim - LIM_W'(1));
    assign last_i   = (LIM_W'(i_reg) == nr_lim - LIM_W'(1));
    assign out_free = !m_valid_reg || m_ready;
    assign acc_sum  = (p2_first_reg ? cbase_reg : acc_reg) + prod_reg;

    assign ab_waddr = {row_i, col_i};
    assign ab_wdata = ELEM_WIDTH'(s_data.value);
    assign a_raddr  = {i_reg, k_reg};
    assign b_raddr  = {k_reg, j_reg};

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        s_ready    = 1'b0;
        a_we       = 1'b0;
        b_we       = 1'b0;
        c_we       = 1'b0;
        c_waddr    = {row_i, col_i};
        c_wdata    = ab_wdata;
        ab_re      = 1'b0;
        c_re       = 1'b0;
        c_raddr    = {row_i, col_i};
        issue      = 1'b0;
        out_load   = 1'b0;
        out_next   = m_data_reg;

        // run writeback, last product of an entry
        if (p2_vld_reg && p2_last_reg) begin
            c_we    = 1'b1;
            c_waddr = {p2_i_reg, p2_j_reg};
            c_wdata = acc_sum;
        end

        case (state_reg)
            ST_CLEAR: begin
                c_we     = 1'b1;
                c_waddr  = clr_reg;
                c_wdata  = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_acc) begin
                    case (s_data.cmd)
                        CMD_WR_A: a_we = in_range;
                        CMD_WR_B: b_we = in_range;
                        CMD_WR_C: c_we = in_range;
                        CMD_RD_C: begin
                            c_re       = 1'b1;
                            state_next = ST_READ;
                        end
                        CMD_RUN: begin
                            i_next = '0;
                            j_next = '0;
                            k_next = '0;
                            if (nr_lim == '0 || ns_lim == '0) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_next.kind      = KIND_READ;
                    out_next.out_row   = rd_row_reg;
                    out_next.out_col   = rd_col_reg;
                    out_next.out_value = rd_in_reg ? 32'(c_rdata) : '0;
                    state_next         = ST_IDLE;
                end
            end
            ST_RUN: begin
                issue   = 1'b1;
                ab_re   = 1'b1;
                c_re    = (k_reg == '0);
                c_raddr = {i_reg, j_reg};
                if (!last_k) begin
                    k_next = k_reg + IDX_W'(1);
                end else begin
                    k_next = '0;
                    if (!last_j) begin
                        j_next = j_reg + IDX_W'(1);
                    end else begin
                        j_next = '0;
                        if (!last_i) begin
                            i_next = i_reg + IDX_W'(1);
                        end else begin
                            i_next     = '0;
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (!p1_vld_reg && !p2_vld_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_next.kind      = KIND_RUN;
                    out_next.out_row   = '0;
                    out_next.out_col   = '0;
                    out_next.out_value = '0;
                    state_next         = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            p1_vld_reg <= issue;
            p2_vld_reg <= p1_vld_reg;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            rd_row_reg <= s_data.row;
            rd_col_reg <= s_data.col;
            rd_in_reg  <= in_range;
        end
        p1_first_reg <= (k_reg == '0);
        p1_last_reg  <= last_k;
        p1_i_reg     <= i_reg;
        p1_j_reg     <= j_reg;
        p2_first_reg <= p1_first_reg;
        p2_last_reg  <= p1_last_reg;
        p2_i_reg     <= p1_i_reg;
        p2_j_reg     <= p1_j_reg;
        // low half of the product wraps like the accumulator
        prod_reg     <= ELEM_WIDTH'(a_rdata * b_rdata);
        if (p1_vld_reg && p1_first_reg) begin
            cbase_reg <= c_rdata;
        end
        if (p2_vld_reg) begin
            acc_reg <= acc_sum;
        end
        if (out_load) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // products only in flight while a run is active
    a_pipe_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_vld_reg |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("MAC product outside a run");

    // run finished is reported only after the last writeback
    a_done_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (!p1_vld_reg && !p2_vld_reg))
        else $error("run finished with MAC pipeline busy");

    // a pending read result waits while the output register is stalled
    a_read_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ && m_valid_reg && !m_ready) |=> (state_reg == ST_READ))
        else $error("read result dropped under stall");

endmodule

`default_nettype wire

>>> hw/rtl/imma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module imma_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 4096,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
